/* rtl/ffc_pkg.sv */
// ffc_pkg: shared types, constants and codes for the flat-field correction block
// no dependencies
package ffc_pkg;

    localparam int MAX_SIDE_DEF   = 4096;
    localparam int MEAN_FRAC_DEF  = 8;

    localparam int PIX_W  = 16;
    localparam int POS_W  = 24;
    localparam int SUM_W  = 40;
    localparam int MEAN_W = 24;
    localparam int CFG_W  = 13;
    localparam int BRD_W  = 11;
    localparam int IDX_W  = 2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1792;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1792;
    localparam logic [BRD_W-1:0] BORDER_RST = 11'd100;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BORDER = 2'd2;

    localparam int Q_DEPTH = 4;

    typedef enum logic {
        K_GAIN    = 1'b0,
        K_CORRECT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             zero_gain;
        logic [PIX_W-1:0] diff;
        logic [PIX_W-1:0] gain;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SYNC,
        S_MEAN,
        S_CMUL,
        S_CDIV,
        S_OUT
    } t_back_state;

endpackage

/* rtl/ffc_front.sv */
// ffc_front: input stage, takes items and classifies them
// depends on ffc_pkg
module ffc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_action,
    input  logic [ffc_pkg::PIX_W-1:0]  i_raw_pixel,
    input  logic [ffc_pkg::PIX_W-1:0]  i_dark_pixel,
    input  logic [ffc_pkg::PIX_W-1:0]  i_gain_pixel,
    output logic                       o_q_push,
    output ffc_pkg::t_item             o_q_item,
    input  logic                       i_q_full
);

    logic           r_valid;
    ffc_pkg::t_item r_item;
    ffc_pkg::t_item n_item;
    logic           w_load;

    assign o_full   = r_valid && i_q_full;
    assign w_load   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_item = r_item;

    // absolute difference and zero-gain flag worked out up front
    always_comb begin
        n_item.kind      = i_action ? ffc_pkg::K_CORRECT : ffc_pkg::K_GAIN;
        n_item.zero_gain = (i_gain_pixel == '0);
        n_item.diff      = (i_raw_pixel >= i_dark_pixel) ? (i_raw_pixel - i_dark_pixel)
                                                         : (i_dark_pixel - i_raw_pixel);
        n_item.gain      = i_gain_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/ffc_queue.sv */
// ffc_queue: short item queue between front and back
// depends on ffc_pkg
module ffc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ffc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output ffc_pkg::t_item o_item,
    output logic           o_empty
);

    localparam int AW = $clog2(ffc_pkg::Q_DEPTH);

    ffc_pkg::t_item r_mem [ffc_pkg::Q_DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_cnt == (AW+1)'(ffc_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* rtl/ffc_div.sv */
// ffc_div: restoring divider, one quotient bit per cycle
// no package dependencies
module ffc_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CW = $clog2(DVD_W+1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_d;
    logic [DVS_W:0]   w_t;
    logic             w_ge;

    assign w_t    = {r_rem, r_q[DVD_W-1]};
    assign w_ge   = (w_t >= {1'b0, r_d});
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? DVS_W'(w_t - {1'b0, r_d}) : w_t[DVS_W-1:0];
        end
    end

endmodule

/* rtl/ffc_back.sv */
// ffc_back: carries out items: gain statistics, mean and pixel correction
// depends on ffc_pkg and ffc_div
module ffc_back #(
    parameter int MAX_SIDE       = ffc_pkg::MAX_SIDE_DEF,
    parameter int MEAN_FRAC_BITS = ffc_pkg::MEAN_FRAC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ffc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [ffc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_q_empty,
    input  ffc_pkg::t_item              i_q_item,
    output logic                        o_q_pop,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [ffc_pkg::PIX_W-1:0]   o_corrected_pixel,
    output logic                        o_clipped,
    output logic [ffc_pkg::MEAN_W-1:0]  o_mean_in_use
);

    localparam int SIDE_W = $clog2(MAX_SIDE+1);
    localparam int LAST_W = 2*SIDE_W;
    localparam int PROD_W = ffc_pkg::PIX_W + ffc_pkg::MEAN_W;
    localparam int DVD_W  = ffc_pkg::SUM_W + MEAN_FRAC_BITS;
    localparam int GDV_W  = ffc_pkg::PIX_W + MEAN_FRAC_BITS;
    localparam int DVS_W  = (GDV_W > LAST_W) ? GDV_W : LAST_W;
    localparam int CMP_W  = ffc_pkg::POS_W + LAST_W;
    localparam int RW     = ffc_pkg::POS_W + 2;
    localparam logic [ffc_pkg::SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [ffc_pkg::MEAN_W-1:0] MEAN_MAX = '1;
    localparam logic [ffc_pkg::PIX_W-1:0]  PIX_MAX  = '1;

    // configuration
    logic [ffc_pkg::CFG_W-1:0] r_cfg_w;
    logic [ffc_pkg::CFG_W-1:0] r_cfg_h;
    logic [ffc_pkg::BRD_W-1:0] r_cfg_b;

    // derived frame geometry, refreshed every cycle
    logic [SIDE_W-1:0] w_wc;
    logic [SIDE_W-1:0] w_hc;
    logic [SIDE_W-1:0] r_wc;
    logic [SIDE_W-1:0] r_hc;
    logic [LAST_W-1:0] r_last;
    logic [LAST_W-1:0] r_area;
    logic              r_nonempty;
    logic [ffc_pkg::BRD_W:0] w_b2;
    logic              w_nonempty;
    logic              w_width_wr;

    ffc_pkg::t_back_state r_state, n_state;
    logic [ffc_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [ffc_pkg::POS_W-1:0]  r_row, n_row;
    logic [SIDE_W-1:0]          r_col, n_col;
    logic [ffc_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [ffc_pkg::MEAN_W-1:0] r_mean, n_mean;
    logic                       r_synced, n_synced;
    logic [PROD_W-1:0]          r_prod, n_prod;
    logic [ffc_pkg::PIX_W-1:0]  r_gain, n_gain;
    logic [ffc_pkg::PIX_W-1:0]  r_res_pix, n_res_pix;
    logic                       r_res_clip, n_res_clip;
    logic                       r_ov, n_ov;
    logic [ffc_pkg::PIX_W-1:0]  r_out_pix, n_out_pix;
    logic                       r_out_clip, n_out_clip;
    logic [ffc_pkg::MEAN_W-1:0] r_out_mean, n_out_mean;

    logic                       w_in_region;
    logic [ffc_pkg::SUM_W:0]    w_sum_add;
    logic [ffc_pkg::SUM_W-1:0]  w_sum_upd;

    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_busy;
    logic             div_done;
    logic [DVD_W-1:0] div_quot;
    logic [DVS_W-1:0] div_rem;

    ffc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // side clamp to 1..MAX_SIDE
    always_comb begin
        if (r_cfg_w == '0) begin
            w_wc = SIDE_W'(1);
        end else if (32'(r_cfg_w) > MAX_SIDE) begin
            w_wc = SIDE_W'(MAX_SIDE);
        end else begin
            w_wc = SIDE_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            w_hc = SIDE_W'(1);
        end else if (32'(r_cfg_h) > MAX_SIDE) begin
            w_hc = SIDE_W'(MAX_SIDE);
        end else begin
            w_hc = SIDE_W'(r_cfg_h);
        end
    end

    assign w_b2       = {r_cfg_b, 1'b0};
    assign w_nonempty = (32'(w_wc) > 32'(w_b2)) && (32'(w_hc) > 32'(w_b2));
    assign w_width_wr = i_cfg_we && (i_cfg_idx == ffc_pkg::REG_WIDTH);

    always_ff @(posedge i_clk) begin
        r_wc       <= w_wc;
        r_hc       <= w_hc;
        r_last     <= LAST_W'(w_wc) * LAST_W'(w_hc) - 1'b1;
        r_nonempty <= w_nonempty;
        r_area     <= LAST_W'(SIDE_W'(32'(w_wc) - 32'(w_b2)))
                    * LAST_W'(SIDE_W'(32'(w_hc) - 32'(w_b2)));
    end

    // mean region test on the current row and column
    assign w_in_region = (RW'(r_row) >= RW'(r_cfg_b))
                      && (RW'(r_row) + RW'(r_cfg_b) + 1'b1 <= RW'(r_hc))
                      && (RW'(r_col) >= RW'(r_cfg_b) + 1'b1)
                      && (RW'(r_col) + RW'(r_cfg_b) <= RW'(r_wc));
    assign w_sum_add = {1'b0, r_sum} + (ffc_pkg::SUM_W+1)'(i_q_item.gain);
    assign w_sum_upd = !w_in_region ? r_sum
                     : (w_sum_add[ffc_pkg::SUM_W] ? SUM_MAX : w_sum_add[ffc_pkg::SUM_W-1:0]);

    assign o_empty           = !r_ov;
    assign o_corrected_pixel = r_out_pix;
    assign o_clipped         = r_out_clip;
    assign o_mean_in_use     = r_out_mean;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_row      = r_row;
        n_col      = r_col;
        n_sum      = r_sum;
        n_mean     = r_mean;
        n_synced   = r_synced;
        n_prod     = r_prod;
        n_gain     = r_gain;
        n_res_pix  = r_res_pix;
        n_res_clip = r_res_clip;
        n_ov       = r_ov;
        n_out_pix  = r_out_pix;
        n_out_clip = r_out_clip;
        n_out_mean = r_out_mean;
        o_q_pop    = 1'b0;
        div_start  = 1'b0;
        div_dvd    = DVD_W'(r_pos);
        // clamped width straight from the register, as the registered copy r_wc lags behind it
        div_dvs    = DVS_W'(w_wc);

        if (r_ov && i_pop) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ffc_pkg::S_IDLE: begin
                if (!r_synced) begin
                    div_start = 1'b1;
                    n_state   = ffc_pkg::S_SYNC;
                end else if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.kind == ffc_pkg::K_GAIN) begin
                        if (CMP_W'(r_pos) >= CMP_W'(r_last)) begin
                            if (r_nonempty) begin
                                n_sum     = w_sum_upd;
                                div_dvd   = DVD_W'(w_sum_upd) << MEAN_FRAC_BITS;
                                div_dvs   = DVS_W'(r_area);
                                div_start = 1'b1;
                                n_state   = ffc_pkg::S_MEAN;
                            end else begin
                                n_mean = '0;
                                n_sum  = '0;
                                n_pos  = '0;
                                n_row  = '0;
                                n_col  = '0;
                            end
                        end else begin
                            n_sum = w_sum_upd;
                            n_pos = r_pos + 1'b1;
                            if (r_col + 1'b1 == r_wc) begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                    end else if (i_q_item.zero_gain) begin
                        n_res_pix  = PIX_MAX;
                        n_res_clip = 1'b1;
                        n_state    = ffc_pkg::S_OUT;
                    end else begin
                        n_prod  = PROD_W'(i_q_item.diff) * PROD_W'(r_mean);
                        n_gain  = i_q_item.gain;
                        n_state = ffc_pkg::S_CMUL;
                    end
                end
            end
            ffc_pkg::S_SYNC: begin
                if (div_done) begin
                    n_row    = div_quot[ffc_pkg::POS_W-1:0];
                    n_col    = div_rem[SIDE_W-1:0];
                    n_synced = 1'b1;
                    n_state  = ffc_pkg::S_IDLE;
                end
            end
            ffc_pkg::S_MEAN: begin
                if (div_done) begin
                    n_mean  = (div_quot > DVD_W'(MEAN_MAX)) ? MEAN_MAX
                                                            : div_quot[ffc_pkg::MEAN_W-1:0];
                    n_sum   = '0;
                    n_pos   = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = ffc_pkg::S_IDLE;
                end
            end
            ffc_pkg::S_CMUL: begin
                div_dvd   = DVD_W'(r_prod);
                div_dvs   = DVS_W'(r_gain) << MEAN_FRAC_BITS;
                div_start = 1'b1;
                n_state   = ffc_pkg::S_CDIV;
            end
            ffc_pkg::S_CDIV: begin
                if (div_done) begin
                    if (div_quot > DVD_W'(PIX_MAX)) begin
                        n_res_pix  = PIX_MAX;
                        n_res_clip = 1'b1;
                    end else begin
                        n_res_pix  = div_quot[ffc_pkg::PIX_W-1:0];
                        n_res_clip = 1'b0;
                    end
                    n_state = ffc_pkg::S_OUT;
                end
            end
            ffc_pkg::S_OUT: begin
                if (!r_ov || i_pop) begin
                    n_ov       = 1'b1;
                    n_out_pix  = r_res_pix;
                    n_out_clip = r_res_clip;
                    n_out_mean = r_mean;
                    n_state    = ffc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffc_pkg::S_IDLE;
            r_pos    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_sum    <= '0;
            r_mean   <= '0;
            r_synced <= 1'b1;
            r_ov     <= 1'b0;
            r_cfg_w  <= ffc_pkg::WIDTH_RST;
            r_cfg_h  <= ffc_pkg::HEIGHT_RST;
            r_cfg_b  <= ffc_pkg::BORDER_RST;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_row    <= n_row;
            r_col    <= n_col;
            r_sum    <= n_sum;
            r_mean   <= n_mean;
            // a new width needs row and column derived again
            r_synced <= n_synced && !w_width_wr;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ffc_pkg::REG_WIDTH: begin
                        r_cfg_w <= i_cfg_data;
                    end
                    ffc_pkg::REG_HEIGHT: begin
                        r_cfg_h <= i_cfg_data;
                    end
                    ffc_pkg::REG_BORDER: begin
                        r_cfg_b <= i_cfg_data[ffc_pkg::BRD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_gain     <= n_gain;
        r_res_pix  <= n_res_pix;
        r_res_clip <= n_res_clip;
        r_out_pix  <= n_out_pix;
        r_out_clip <= n_out_clip;
        r_out_mean <= n_out_mean;
    end

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffc_pkg::S_MEAN && div_done) |=> (r_pos == '0 && r_sum == '0))
        else $error("frame end did not clear position and sum");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out_clip) |-> (r_out_pix == PIX_MAX))
        else $error("clipped result not saturated");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ffc_pkg::S_IDLE && r_synced))
        else $error("queue popped while busy");

endmodule

/* rtl/flat_field_correction_top.sv */
// flow: front register, queue, then the back end, which adds a gain item to the region sum
// or clips a correct item on zero gain, else multiplies and divides it; the last gain item
// of a frame holds the back end while the bit-serial divider forms the mean
// throughput: one gain item per cycle while the back end is idle, none while it is busy
// reset: synchronous active low; clears position, sum, mean, queue and output
// a frame width write re-derives row and column with one divider pass before the next item
module flat_field_correction_top #(
    parameter int MAX_SIDE       = ffc_pkg::MAX_SIDE_DEF,
    parameter int MEAN_FRAC_BITS = ffc_pkg::MEAN_FRAC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [ffc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [ffc_pkg::CFG_W-1:0]   i_cfg_data,
    // input item queue side
    input  logic                        push,
    output logic                        full,
    input  logic                        i_action,
    input  logic [ffc_pkg::PIX_W-1:0]   i_raw_pixel,
    input  logic [ffc_pkg::PIX_W-1:0]   i_dark_pixel,
    input  logic [ffc_pkg::PIX_W-1:0]   i_gain_pixel,
    // result queue side
    output logic                        empty,
    input  logic                        pop,
    output logic [ffc_pkg::PIX_W-1:0]   o_corrected_pixel,
    output logic                        o_clipped,
    output logic [ffc_pkg::MEAN_W-1:0]  o_mean_in_use
);

    // front stage to queue
    logic           f_push;
    ffc_pkg::t_item f_item;
    logic           q_full;
    // queue to back end
    logic           q_empty;
    logic           q_pop;
    ffc_pkg::t_item q_item;

    // front: registers one item, takes abs difference and flags zero gain
    ffc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_raw_pixel  (i_raw_pixel),
        .i_dark_pixel (i_dark_pixel),
        .i_gain_pixel (i_gain_pixel),
        .o_q_push     (f_push),
        .o_q_item     (f_item),
        .i_q_full     (q_full)
    );

    // short queue lets the front keep taking gain items while the back divides
    ffc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    // back: position tracking, region sum, shared divider, result register
    ffc_back #(
        .MAX_SIDE       (MAX_SIDE),
        .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_q_empty         (q_empty),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_corrected_pixel (o_corrected_pixel),
        .o_clipped         (o_clipped),
        .o_mean_in_use     (o_mean_in_use)
    );

endmodule
